// ===== design/rkf_pkg.sv =====
package rkf_pkg;

    localparam int CHAN_W = 8;
    localparam int SUM_W = 12;
    localparam int ADJ_W = 14;
    localparam int INT_W = 10;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_SCALE_W = 8;
    localparam int DIV_STEPS = SUM_W;

    localparam logic [INT_W-1:0] INTENSITY_ABOVE_MAX = 10'd766;
    localparam logic [SUM_W-1:0] CHANNEL_MAX = 12'd255;

    localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = 11'd512;
    localparam logic [CFG_SIZE_W-1:0] SIZE_MIN = 11'd3;
    localparam logic [CFG_SCALE_W-1:0] SCALE_RESET = 8'd9;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;
    localparam logic [1:0] REG_KERNEL_SCALE = 2'd1;
    localparam logic [1:0] REG_FILTER_ENABLE = 2'd2;
    localparam logic [1:0] REG_SHARPEN_ENABLE = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } rkf_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } rkf_out_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rkf_pix_t;

    typedef struct packed {
        logic shift;
        logic reduce;
    } win_ctrl_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        rkf_pix_t              ctr;
        rkf_pix_t              lo_px;
        rkf_pix_t              hi_px;
    } win_sum_t;

    function automatic logic [7:0] px_chan(rkf_pix_t p, logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0: v = p.r;
            2'd1: v = p.g;
            default: v = p.b;
        endcase
        return v;
    endfunction

endpackage

// ===== design/rkf_ram.sv =====
module rkf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rkf_window.sv =====
module rkf_window (
    input  logic               aclk,
    input  logic               aresetn,
    input  rkf_pkg::win_ctrl_t ctrl,
    input  rkf_pkg::rkf_pix_t  top_px,
    input  rkf_pkg::rkf_pix_t  mid_px,
    input  rkf_pkg::rkf_pix_t  new_px,
    output rkf_pkg::win_sum_t  red_out
);
    import rkf_pkg::*;

    rkf_pix_t win_reg [9];
    win_sum_t red_reg;
    win_sum_t red_next;

    logic [INT_W-1:0] t_val;
    logic [INT_W-1:0] lo_t;
    logic [INT_W-1:0] hi_t;
    logic [3:0]       lo_i;
    logic [3:0]       hi_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (ctrl.shift) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= top_px;
            win_reg[5] <= mid_px;
            win_reg[8] <= new_px;
        end
    end

    // lo keeps the last minimum, hi the first maximum
    always_comb begin
        red_next = red_reg;
        lo_t = INTENSITY_ABOVE_MAX;
        hi_t = '0;
        lo_i = '0;
        hi_i = '0;
        t_val = '0;
        for (int k = 0; k < 3; k++) begin
            red_next.sum[k] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            t_val = INT_W'(win_reg[i].r) + INT_W'(win_reg[i].g) + INT_W'(win_reg[i].b);
            for (int k = 0; k < 3; k++) begin
                red_next.sum[k] = red_next.sum[k] + SUM_W'(px_chan(win_reg[i], 2'(k)));
            end
            if (t_val <= lo_t) begin
                lo_t = t_val;
                lo_i = 4'(i);
            end
            if (i == 0 || t_val > hi_t) begin
                hi_t = t_val;
                hi_i = 4'(i);
            end
        end
        red_next.ctr = win_reg[4];
        red_next.lo_px = win_reg[lo_i];
        red_next.hi_px = win_reg[hi_i];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.reduce) begin
            red_reg <= red_next;
        end
    end

    assign red_out = red_reg;

endmodule

// ===== design/rkf_div.sv =====
module rkf_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [2:0][rkf_pkg::SUM_W-1:0]      num,
    input  logic [rkf_pkg::CFG_SCALE_W-1:0]     den,
    output logic                                busy,
    output logic [2:0][7:0]                     quo
);
    import rkf_pkg::*;

    logic                    busy_reg, busy_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [CFG_SCALE_W-1:0]  den_reg;
    logic [2:0][SUM_W-1:0]   num_reg, num_next;
    logic [2:0][SUM_W-1:0]   q_reg, q_next;
    logic [2:0][7:0]         rem_reg, rem_next;
    logic [8:0]              trial;
    logic                    ge;

    always_comb begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        trial = '0;
        ge = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = '0;
            num_next = num;
            q_next = '0;
            rem_next = '0;
        end else if (busy_reg) begin
            // one restoring step per channel
            for (int k = 0; k < 3; k++) begin
                trial = {rem_reg[k], num_reg[k][SUM_W-1]};
                ge = trial >= {1'b0, den_reg};
                rem_next[k] = ge ? 8'(trial - {1'b0, den_reg}) : trial[7:0];
                q_next[k] = {q_reg[k][SUM_W-2:0], ge};
                num_next[k] = {num_reg[k][SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
        end
        num_reg <= num_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            quo[k] = (q_reg[k] > CHANNEL_MAX) ? 8'hFF : q_reg[k][7:0];
        end
    end

    assign busy = busy_reg;

endmodule

// ===== design/rgb_3x3_kernel_filter_top.sv =====
// path: a pixel that completes a result goes from acceptance through READ, SUM and ADJ to
// DONE on the border, and through the 12-step divider (DIV) for the scale on the interior
// a new transaction is taken only once the previous one is back in IDLE; the line
// memories are read and written back once per transaction
// reset: synchronous active low; a clearing pass over all MAX_SIZE addresses zeroes the line
// memories, during which no pixel is taken (register writes still go through)
module rgb_3x3_kernel_filter_top #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rkf_pkg::rkf_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rkf_pkg::rkf_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rkf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rkf_pkg::*;

    localparam int POS_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int FW = $clog2(MAX_SIZE + 2);
    localparam int CW = (FW > CFG_SIZE_W) ? FW : CFG_SIZE_W;
    localparam logic [CW-1:0] MAX_SZ = CW'(MAX_SIZE);
    localparam logic [POS_W-1:0] CLR_LAST = POS_W'(MAX_SIZE - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_SUM   = 7'b0001000,
        ST_ADJ   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_SIZE_W-1:0]  image_size_reg;
    logic [CFG_SCALE_W-1:0] kernel_scale_reg;
    logic                   filter_enable_reg;
    logic                   sharpen_enable_reg;

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0] clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;
    rkf_out_t         m_data_reg, m_data_next;

    rkf_pix_t pix_reg;
    logic     flush_reg;
    logic     border_reg;
    logic     last_reg;
    logic     border_next;
    logic     last_next;

    logic [CW-1:0] eff_size;
    logic [CW-1:0] size_p1;
    logic [CW-1:0] row_w, col_w, r_pos, c_pos;
    logic          pos_out;
    logic [CW-1:0] fill_w;
    logic [FW-1:0] fill_norm;
    logic [POS_W-1:0] row_norm, col_norm;
    logic          s_acc;
    logic          cfg_wr;

    logic          ram_we;
    logic [POS_W-1:0] ram_waddr, ram_raddr;
    rkf_pix_t      top_rd, mid_rd, top_wd, mid_wd;

    win_ctrl_t     wctrl;
    win_sum_t      wsum;

    logic                  div_start;
    logic                  div_busy;
    logic [2:0][SUM_W-1:0] div_num;
    logic [2:0][7:0]       div_quo;
    logic [CFG_SCALE_W-1:0] scale_eff;
    logic signed [ADJ_W-1:0] adj [3];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= SIZE_RESET;
            kernel_scale_reg <= SCALE_RESET;
            filter_enable_reg <= 1'b0;
            sharpen_enable_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_SIZE:     image_size_reg <= pwdata[CFG_SIZE_W-1:0];
                REG_KERNEL_SCALE:   kernel_scale_reg <= pwdata[CFG_SCALE_W-1:0];
                REG_FILTER_ENABLE:  filter_enable_reg <= pwdata[0];
                REG_SHARPEN_ENABLE: sharpen_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_SIZE:     prdata = 32'(image_size_reg);
            REG_KERNEL_SCALE:   prdata = 32'(kernel_scale_reg);
            REG_FILTER_ENABLE:  prdata = 32'(filter_enable_reg);
            REG_SHARPEN_ENABLE: prdata = 32'(sharpen_enable_reg);
            default:            prdata = '0;
        endcase
    end

    // effective frame size, position clean-up and zero-scale guard at transaction time
    always_comb begin
        if (image_size_reg < SIZE_MIN) begin
            eff_size = CW'(SIZE_MIN);
        end else if (CW'(image_size_reg) > MAX_SZ) begin
            eff_size = MAX_SZ;
        end else begin
            eff_size = CW'(image_size_reg);
        end
        size_p1 = eff_size + CW'(1);
        row_w = CW'(row_reg);
        col_w = CW'(col_reg);
        pos_out = (row_w >= eff_size) || (col_w >= eff_size);
        row_norm = pos_out ? '0 : row_reg;
        col_norm = pos_out ? '0 : col_reg;
        fill_w = CW'(fill_reg);
        fill_norm = (fill_w > size_p1) ? FW'(size_p1) : fill_reg;
        scale_eff = (kernel_scale_reg == '0) ? CFG_SCALE_W'(1) : kernel_scale_reg;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        fill_next = fill_reg;
        clr_next = clr_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        border_next = border_reg;
        last_next = last_reg;
        r_pos = '0;
        c_pos = '0;
        ram_we = 1'b0;
        ram_waddr = col_reg;
        ram_raddr = col_norm;
        top_wd = mid_rd;
        mid_wd = pix_reg;
        wctrl = '0;
        div_start = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                top_wd = '0;
                mid_wd = '0;
                clr_next = clr_reg + POS_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    row_next = row_norm;
                    col_next = col_norm;
                    fill_next = fill_norm;
                    if (!(s_data.op && fill_norm == '0)) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                ram_we = 1'b1;
                wctrl.shift = 1'b1;
                if (col_w + CW'(1) >= eff_size) begin
                    col_next = '0;
                    row_next = (row_w + CW'(1) >= eff_size) ? '0 : POS_W'(row_w + CW'(1));
                end else begin
                    col_next = POS_W'(col_w + CW'(1));
                end
                if (col_w == '0) begin
                    c_pos = eff_size - CW'(1);
                    r_pos = (row_w >= CW'(2)) ? row_w - CW'(2) : row_w + eff_size - CW'(2);
                end else begin
                    c_pos = col_w - CW'(1);
                    r_pos = (row_w >= CW'(1)) ? row_w - CW'(1) : eff_size - CW'(1);
                end
                border_next = (r_pos == '0) || (c_pos == '0) ||
                              (r_pos == eff_size - CW'(1)) || (c_pos == eff_size - CW'(1));
                last_next = (r_pos == eff_size - CW'(1)) && (c_pos == eff_size - CW'(1));
                if (flush_reg) begin
                    fill_next = fill_reg - FW'(1);
                    if (fill_reg == FW'(1)) begin
                        row_next = '0;
                        col_next = '0;
                    end
                    state_next = ST_SUM;
                end else if (CW'(fill_reg) == size_p1) begin
                    state_next = ST_SUM;
                end else begin
                    fill_next = fill_reg + FW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                wctrl.reduce = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ: begin
                if (border_reg) begin
                    state_next = ST_DONE;
                end else begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (border_reg) begin
                        m_data_next.out_red = wsum.ctr.r;
                        m_data_next.out_green = wsum.ctr.g;
                        m_data_next.out_blue = wsum.ctr.b;
                    end else begin
                        m_data_next.out_red = div_quo[0];
                        m_data_next.out_green = div_quo[1];
                        m_data_next.out_blue = div_quo[2];
                    end
                    m_data_next.frame_last = last_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // channel sums after kernel choice and min/max trimming
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            adj[k] = ADJ_W'(wsum.sum[k]);
            if (sharpen_enable_reg) begin
                adj[k] = ADJ_W'(10) * ADJ_W'(px_chan(wsum.ctr, 2'(k))) - adj[k];
            end
            if (filter_enable_reg) begin
                adj[k] = adj[k] - ADJ_W'(px_chan(wsum.lo_px, 2'(k)))
                                - ADJ_W'(px_chan(wsum.hi_px, 2'(k)));
            end
            div_num[k] = (adj[k] <= 0) ? '0 : adj[k][SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            row_reg <= '0;
            col_reg <= '0;
            fill_reg <= '0;
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            fill_reg <= fill_next;
            clr_reg <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            flush_reg <= s_data.op;
            pix_reg <= s_data.op ? '0 : rkf_pix_t'({s_data.in_red, s_data.in_green,
                                                    s_data.in_blue});
        end
        border_reg <= border_next;
        last_reg <= last_next;
        m_data_reg <= m_data_next;
    end

    rkf_ram #(.WIDTH($bits(rkf_pix_t)), .DEPTH(MAX_SIZE)) u_top_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_wd),
        .raddr (ram_raddr),
        .rdata (top_rd)
    );

    rkf_ram #(.WIDTH($bits(rkf_pix_t)), .DEPTH(MAX_SIZE)) u_mid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (mid_wd),
        .raddr (ram_raddr),
        .rdata (mid_rd)
    );

    rkf_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (wctrl),
        .top_px  (top_rd),
        .mid_px  (mid_rd),
        .new_px  (pix_reg),
        .red_out (wsum)
    );

    rkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (scale_eff),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider busy outside its state");

    a_done_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=>
            (state_reg == ST_IDLE && m_valid_reg))
        else $error("finished result not presented");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(fill_reg) <= MAX_SZ + CW'(1))
        else $error("pending count overflow");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("transaction taken during memory clear");

endmodule
